// ===== rtl/rsa_pkg.sv =====
// Shared types and default sizes for the rational sum accumulator.
`timescale 1ns / 1ps

package rsa_pkg;

    localparam int ACC_WIDTH_DEF  = 32;
    localparam int TERM_WIDTH_DEF = 11;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take input word; clear sum on start if den nonzero
        logic mul_step;  // one shift-and-add step of the three products
        logic check;     // range checks, signed combine
        logic fail;      // flag overflow, keep the sum
        logic gcd_step;  // one binary gcd step
        logic div_init;  // load both dividers with the gcd
        logic div_step;  // one restoring division step
        logic commit;    // write the reduced sum back
        logic out_load;  // capture the result word
    } rsa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_bad;    // input denominator is zero
        logic mul_last;
        logic lim_ok;
        logic sum_ok;
        logic gcd_done;
        logic div_last;
    } rsa_status_t;

endpackage

// ===== rtl/rsa_ctrl.sv =====
// Sequencing state machine of the rational sum accumulator.
`timescale 1ns / 1ps

module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  rsa_status_t status,
    output rsa_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_EVAL,
        ST_GCD,
        ST_DIV,
        ST_COMMIT,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_bad ? ST_WRITE : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.mul_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.lim_ok && status.sum_ok) begin
                    state_next = ST_GCD;
                end else begin
                    cmd.fail   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_GCD: begin
                if (status.gcd_done) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/rsa_datapath.sv =====
// Datapath of the rational sum accumulator: products, combine, gcd, division.
`timescale 1ns / 1ps

module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    parameter int TERM_WIDTH = TERM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rsa_cmd_t                     cmd,
    output rsa_status_t                  status,
    input  logic                         start_new,
    input  logic signed [TERM_WIDTH-1:0] term_numerator,
    input  logic        [TERM_WIDTH-2:0] term_denominator,
    output logic signed [ACC_WIDTH-1:0]  sum_numerator,
    output logic        [ACC_WIDTH-2:0]  sum_denominator,
    output logic                         bad_term,
    output logic                         overflowed
);

    localparam int W   = ACC_WIDTH;
    localparam int T   = TERM_WIDTH;
    localparam int PW  = W + T;
    localparam int KW  = $clog2(W);
    localparam int MCW = $clog2(T);

    localparam logic [PW-1:0] POS_LIM_P = {{(PW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [PW-1:0] NEG_LIM_P = POS_LIM_P + PW'(1);
    localparam logic [W:0]    POS_LIM_S = POS_LIM_P[W:0];
    localparam logic [W:0]    NEG_LIM_S = NEG_LIM_P[W:0];

    // sum state
    logic          acc_neg_reg, acc_neg_next;
    logic [W-1:0]  acc_mag_reg, acc_mag_next;
    logic [W-2:0]  acc_den_reg, acc_den_next;
    logic          ovf_reg, ovf_next;

    // working registers
    logic          bad_reg, bad_next;
    logic          tneg_reg, tneg_next;
    logic [T-2:0]  b_sh_reg, b_sh_next;
    logic [T-1:0]  t_sh_reg, t_sh_next;
    logic [MCW-1:0] mul_cnt_reg, mul_cnt_next;
    logic [PW-1:0] mc_mag_reg, mc_mag_next;
    logic [PW-1:0] mc_den_reg, mc_den_next;
    logic [PW-1:0] p1_reg, p1_next;
    logic [PW-1:0] p2_reg, p2_next;
    logic [PW-1:0] pd_reg, pd_next;
    logic          lim_ok_reg, lim_ok_next;
    logic          sum_ok_reg, sum_ok_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  mag_reg, mag_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W-1:0]  u_reg, u_next;
    logic [W-1:0]  v_reg, v_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  g_reg, g_next;
    logic [W-1:0]  q1_reg, q1_next;
    logic [W-1:0]  q2_reg, q2_next;
    logic [W-1:0]  r1_reg, r1_next;
    logic [W-1:0]  r2_reg, r2_next;
    logic [KW-1:0] div_cnt_reg, div_cnt_next;

    // output word
    logic [W-1:0]  out_num_reg, out_num_next;
    logic [W-2:0]  out_den_reg, out_den_next;
    logic          out_bad_reg, out_bad_next;
    logic          out_ovf_reg, out_ovf_next;

    // input decode
    logic [T-1:0]  in_raw;
    logic          in_neg;
    logic [T-1:0]  in_mag;
    logic          in_bad;
    logic          in_clr;

    // combine
    logic [W:0]    a1, a2, add_s, lim_s;
    logic          same_sign, a1_ge;

    // division
    logic [W:0]    t1, t2, gx;

    assign in_raw = T'(term_numerator);
    assign in_neg = in_raw[T-1];
    assign in_mag = in_neg ? (T'(0) - in_raw) : in_raw;
    assign in_bad = (term_denominator == '0);
    assign in_clr = start_new && !in_bad;

    assign a1        = {1'b0, p1_reg[W-1:0]};
    assign a2        = {1'b0, p2_reg[W-1:0]};
    assign add_s     = a1 + a2;
    assign lim_s     = acc_neg_reg ? NEG_LIM_S : POS_LIM_S;
    assign same_sign = (acc_neg_reg == tneg_reg);
    assign a1_ge     = (a1 >= a2);

    assign gx = {1'b0, g_reg};
    assign t1 = {r1_reg, q1_reg[W-1]};
    assign t2 = {r2_reg, q2_reg[W-1]};

    always_comb begin
        acc_neg_next = acc_neg_reg;
        acc_mag_next = acc_mag_reg;
        acc_den_next = acc_den_reg;
        ovf_next     = ovf_reg;
        bad_next     = bad_reg;
        tneg_next    = tneg_reg;
        b_sh_next    = b_sh_reg;
        t_sh_next    = t_sh_reg;
        mul_cnt_next = mul_cnt_reg;
        mc_mag_next  = mc_mag_reg;
        mc_den_next  = mc_den_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        pd_next      = pd_reg;
        lim_ok_next  = lim_ok_reg;
        sum_ok_next  = sum_ok_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        den_next     = den_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        q1_next      = q1_reg;
        q2_next      = q2_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        div_cnt_next = div_cnt_reg;
        out_num_next = out_num_reg;
        out_den_next = out_den_reg;
        out_bad_next = out_bad_reg;
        out_ovf_next = out_ovf_reg;

        if (cmd.load) begin
            bad_next     = in_bad;
            tneg_next    = in_neg;
            b_sh_next    = term_denominator;
            t_sh_next    = in_mag;
            mul_cnt_next = MCW'(T - 1);
            p1_next      = '0;
            p2_next      = '0;
            pd_next      = '0;
            if (in_clr) begin
                acc_neg_next = 1'b0;
                acc_mag_next = '0;
                acc_den_next = (W - 1)'(1);
                ovf_next     = 1'b0;
                mc_mag_next  = '0;
                mc_den_next  = PW'(1);
            end else begin
                mc_mag_next = PW'(acc_mag_reg);
                mc_den_next = PW'(acc_den_reg);
            end
        end

        if (cmd.mul_step) begin
            if (b_sh_reg[0]) begin
                p1_next = p1_reg + mc_mag_reg;
                pd_next = pd_reg + mc_den_reg;
            end
            if (t_sh_reg[0]) begin
                p2_next = p2_reg + mc_den_reg;
            end
            mc_mag_next  = {mc_mag_reg[PW-2:0], 1'b0};
            mc_den_next  = {mc_den_reg[PW-2:0], 1'b0};
            b_sh_next    = b_sh_reg >> 1;
            t_sh_next    = t_sh_reg >> 1;
            mul_cnt_next = mul_cnt_reg - MCW'(1);
        end

        if (cmd.check) begin
            lim_ok_next = (p1_reg <= (acc_neg_reg ? NEG_LIM_P : POS_LIM_P)) &&
                          (p2_reg <= (tneg_reg ? NEG_LIM_P : POS_LIM_P)) &&
                          (pd_reg <= POS_LIM_P);
            if (same_sign) begin
                sum_ok_next = (add_s <= lim_s);
                mag_next    = add_s[W-1:0];
                neg_next    = acc_neg_reg;
            end else begin
                sum_ok_next = 1'b1;
                mag_next    = a1_ge ? (a1[W-1:0] - a2[W-1:0]) : (a2[W-1:0] - a1[W-1:0]);
                neg_next    = a1_ge ? acc_neg_reg : tneg_reg;
            end
            den_next = pd_reg[W-1:0];
            u_next   = mag_next;
            v_next   = pd_reg[W-1:0];
            k_next   = '0;
        end

        if (cmd.fail) begin
            ovf_next = 1'b1;
        end

        // binary gcd: strip common twos, then subtract odd from odd
        if (cmd.gcd_step) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + KW'(1);
            end else if (!u_reg[0]) begin
                u_next = u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_next = v_reg >> 1;
            end else if (u_reg >= v_reg) begin
                u_next = u_reg - v_reg;
            end else begin
                v_next = v_reg - u_reg;
            end
        end

        if (cmd.div_init) begin
            g_next       = v_reg << k_reg;
            q1_next      = mag_reg;
            q2_next      = den_reg;
            r1_next      = '0;
            r2_next      = '0;
            div_cnt_next = KW'(W - 1);
        end

        if (cmd.div_step) begin
            if (t1 >= gx) begin
                r1_next = W'(t1 - gx);
                q1_next = {q1_reg[W-2:0], 1'b1};
            end else begin
                r1_next = t1[W-1:0];
                q1_next = {q1_reg[W-2:0], 1'b0};
            end
            if (t2 >= gx) begin
                r2_next = W'(t2 - gx);
                q2_next = {q2_reg[W-2:0], 1'b1};
            end else begin
                r2_next = t2[W-1:0];
                q2_next = {q2_reg[W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg - KW'(1);
        end

        if (cmd.commit) begin
            acc_mag_next = q1_reg;
            acc_den_next = q2_reg[W-2:0];
            acc_neg_next = neg_reg && (q1_reg != '0);
        end

        if (cmd.out_load) begin
            out_num_next = acc_neg_reg ? (W'(0) - acc_mag_reg) : acc_mag_reg;
            out_den_next = acc_den_reg;
            out_bad_next = bad_reg;
            out_ovf_next = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_neg_reg <= 1'b0;
            acc_mag_reg <= '0;
            acc_den_reg <= (W - 1)'(1);
            ovf_reg     <= 1'b0;
        end else begin
            acc_neg_reg <= acc_neg_next;
            acc_mag_reg <= acc_mag_next;
            acc_den_reg <= acc_den_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        bad_reg     <= bad_next;
        tneg_reg    <= tneg_next;
        b_sh_reg    <= b_sh_next;
        t_sh_reg    <= t_sh_next;
        mul_cnt_reg <= mul_cnt_next;
        mc_mag_reg  <= mc_mag_next;
        mc_den_reg  <= mc_den_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        pd_reg      <= pd_next;
        lim_ok_reg  <= lim_ok_next;
        sum_ok_reg  <= sum_ok_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        den_reg     <= den_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        q1_reg      <= q1_next;
        q2_reg      <= q2_next;
        r1_reg      <= r1_next;
        r2_reg      <= r2_next;
        div_cnt_reg <= div_cnt_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_bad_reg <= out_bad_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign status.in_bad   = in_bad;
    assign status.mul_last = (mul_cnt_reg == '0);
    assign status.lim_ok   = lim_ok_reg;
    assign status.sum_ok   = sum_ok_reg;
    assign status.gcd_done = (u_reg == '0);
    assign status.div_last = (div_cnt_reg == '0);

    assign sum_numerator   = out_num_reg;
    assign sum_denominator = out_den_reg;
    assign bad_term        = out_bad_reg;
    assign overflowed      = out_ovf_reg;

endmodule

// ===== rtl/rational_sum_accumulator_core.sv =====
// Top level of the rational sum accumulator: controller plus datapath.
`timescale 1ns / 1ps
// Usage
//   Input channel (s_valid/s_ready): one word per fraction, s_term_numerator
//   signed, s_term_denominator unsigned, s_start_new clears the running sum
//   to 0/1 and the sticky overflow flag before the fraction is added.
//   Result channel (m_valid/m_ready): one word per input word carrying the
//   reduced sum, bad_term for a zero denominator (word ignored, start too)
//   and the sticky overflow flag. On overflow the sum is held unchanged.
// Sequence
//   One word at a time. A zero-denominator word goes straight from accept
//   to the write state. Any other word runs the shift-and-add product loop,
//   the range check, the binary gcd loop, one step per cycle, and the two
//   restoring dividers run side by side, then commits and writes. An
//   overflowing word skips gcd and division and goes to the write state.
// Reset and stall
//   Synchronous active-low aresetn sets the sum to 0/1 and clears the flag.
//   The result word sits in an output register; a new input word is taken
//   while it waits, and the next result holds until m_ready frees the slot.

module rational_sum_accumulator_core
    import rsa_pkg::*;
#(
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    parameter int TERM_WIDTH = TERM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_start_new,
    input  logic signed [TERM_WIDTH-1:0] s_term_numerator,
    input  logic        [TERM_WIDTH-2:0] s_term_denominator,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [ACC_WIDTH-1:0]  m_sum_numerator,
    output logic        [ACC_WIDTH-2:0]  m_sum_denominator,
    output logic                         m_bad_term,
    output logic                         m_overflowed
);

    // command and status between the sequencer and the arithmetic
    rsa_cmd_t    cmd;
    rsa_status_t status;

    // sequencer: accept, step the loops, drop the result word into the
    // output register once it is free
    rsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic: running sum, products, gcd, division, result word
    rsa_datapath #(
        .ACC_WIDTH  (ACC_WIDTH),
        .TERM_WIDTH (TERM_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .start_new        (s_start_new),
        .term_numerator   (s_term_numerator),
        .term_denominator (s_term_denominator),
        .sum_numerator    (m_sum_numerator),
        .sum_denominator  (m_sum_denominator),
        .bad_term         (m_bad_term),
        .overflowed       (m_overflowed)
    );

endmodule
